### design/rcfd_pkg.sv
package rcfd_pkg;

  localparam int MOTOR_COUNT = 4;

  // latch numbers as written on the latch bus
  localparam logic [3:0] LATCH_MOTOR1   = 4'd1;
  localparam logic [3:0] LATCH_DRIBBLER = 4'd5;
  localparam logic [3:0] LATCH_SERVO    = 4'd6;
  localparam logic [3:0] LATCH_DIRECT   = 4'd7;
  localparam logic [3:0] LATCH_CHIP     = 4'd8;

  // write slot within one burst
  localparam logic [2:0] SLOT_MOTOR1   = 3'd0;
  localparam logic [2:0] SLOT_MOTOR2   = 3'd1;
  localparam logic [2:0] SLOT_MOTOR3   = 3'd2;
  localparam logic [2:0] SLOT_MOTOR4   = 3'd3;
  localparam logic [2:0] SLOT_DRIBBLER = 3'd4;
  localparam logic [2:0] SLOT_SERVO    = 3'd5;
  localparam logic [2:0] SLOT_DIRECT   = 3'd6;
  localparam logic [2:0] SLOT_CHIP     = 3'd7;

  // configuration register indexes
  localparam logic REG_ROBOT_ID = 1'b0;

  typedef logic [MOTOR_COUNT-1:0][7:0] speed_mag_t;

  // everything a finished frame hands to the write sequencer
  typedef struct packed {
    speed_mag_t             speed_mag;
    logic [MOTOR_COUNT-1:0] speed_dir;
    logic [3:0]             direct_kick;
    logic [3:0]             chip_kick;
    logic [1:0]             servo;
    logic                   charge_ok;
    logic                   beep;
    logic                   debug;
    logic                   sos;
    logic [3:0]             dribbler;
  } frame_t;

endpackage

### design/rcfd_parser.sv
module rcfd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic [3:0]            robot_id,
  input  logic                  seq_busy,
  output logic                  frame_done,
  output rcfd_pkg::frame_t      frame
);
  import rcfd_pkg::*;

  localparam logic [2:0] POS_WAIT  = 3'd0;
  localparam logic [2:0] POS_ADDR  = 3'd1;
  localparam logic [2:0] POS_SPD1  = 3'd2;
  localparam logic [2:0] POS_SPD2  = 3'd3;
  localparam logic [2:0] POS_SPD3  = 3'd4;
  localparam logic [2:0] POS_SPD4  = 3'd5;
  localparam logic [2:0] POS_FLAG1 = 3'd6;
  localparam logic [2:0] POS_FLAG2 = 3'd7;

  // servo comes out of reset at setting one
  localparam frame_t FR_RESET = '{speed_mag: '0, speed_dir: '0, direct_kick: 4'd0,
                                  chip_kick: 4'd0, servo: 2'd1, charge_ok: 1'b0,
                                  beep: 1'b0, debug: 1'b0, sos: 1'b0, dribbler: 4'd0};

  logic [2:0] pos_r, pos_nxt;
  frame_t     fr_r, fr_nxt;
  logic       accept;
  logic [7:0] mag_raw;
  logic [1:0] motor;

  // stall only a frame-closing item while the previous burst is still out
  assign in_ready = !(seq_busy && pos_r == POS_FLAG2 && in_rx_byte != 8'd0);
  assign accept   = in_valid && in_ready;

  assign mag_raw = in_rx_byte[7] ? (in_rx_byte - 8'd127) : (8'd127 - in_rx_byte);
  assign motor   = pos_r[1:0] - POS_SPD1[1:0];

  always_comb begin
    pos_nxt    = pos_r;
    fr_nxt     = fr_r;
    frame_done = 1'b0;
    if (accept) begin
      if (in_rx_byte == 8'd0) begin
        pos_nxt = POS_ADDR;
      end else begin
        case (pos_r)
          POS_WAIT: begin
            pos_nxt = POS_WAIT;
          end
          POS_ADDR: begin
            if (in_rx_byte[3:0] == robot_id) begin
              fr_nxt.direct_kick = in_rx_byte[7:4];
              pos_nxt            = POS_SPD1;
            end else begin
              pos_nxt = POS_WAIT;
            end
          end
          POS_SPD1, POS_SPD2, POS_SPD3, POS_SPD4: begin
            fr_nxt.speed_mag[motor] = {mag_raw[6:0], 1'b0};
            fr_nxt.speed_dir[motor] = !in_rx_byte[7];
            pos_nxt                 = pos_r + 3'd1;
          end
          POS_FLAG1: begin
            fr_nxt.servo      = in_rx_byte[1:0];
            fr_nxt.charge_ok  = in_rx_byte[2];
            fr_nxt.chip_kick  = in_rx_byte[7:4];
            pos_nxt           = POS_FLAG2;
          end
          POS_FLAG2: begin
            fr_nxt.beep     = in_rx_byte[0];
            fr_nxt.debug    = in_rx_byte[2];
            fr_nxt.sos      = in_rx_byte[3];
            fr_nxt.dribbler = in_rx_byte[7:4];
            pos_nxt         = POS_WAIT;
            frame_done      = 1'b1;
          end
          default: begin
            pos_nxt = POS_WAIT;
          end
        endcase
      end
    end
  end

  // hand over the frame including the byte that closes it
  assign frame = fr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_WAIT;
      fr_r  <= FR_RESET;
    end else begin
      pos_r <= pos_nxt;
      fr_r  <= fr_nxt;
    end
  end

  a_done_from_flag2: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> (pos_r == POS_FLAG2 && accept))
    else $error("frame closed outside the last byte position");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !seq_busy)
    else $error("frame closed while a burst is still in progress");

  a_zero_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_rx_byte == 8'd0) |=> pos_r == POS_ADDR)
    else $error("zero byte did not restart the frame");

endmodule

### design/rcfd_seq.sv
module rcfd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_done,
  input  rcfd_pkg::frame_t  frame,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_latch_index,
  output logic [1:0]        out_mux_select,
  output logic              out_write_bank,
  output logic [7:0]        out_latch_data,
  output logic [3:0]        out_motor_dirs,
  output logic              out_charge_ok,
  output logic              out_buzzer_on,
  output logic              out_debug_flag,
  output logic              out_sos_flag,
  output logic              out_last
);
  import rcfd_pkg::*;

  frame_t     snap_r;
  logic       busy_r;
  logic [2:0] slot_r;
  logic       can_load;
  logic [7:0] data_nxt;

  logic       out_valid_r;
  logic [2:0] out_slot_r;
  logic [7:0] out_data_r;
  logic [3:0] out_dirs_r;
  logic       out_ready_lvl_r, out_beep_r, out_debug_r, out_sos_r;

  assign busy     = busy_r;
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    case (slot_r)
      SLOT_MOTOR1, SLOT_MOTOR2, SLOT_MOTOR3, SLOT_MOTOR4:
        data_nxt = snap_r.speed_mag[slot_r[1:0]];
      SLOT_DRIBBLER: data_nxt = {snap_r.dribbler, 4'd0};
      SLOT_SERVO:    data_nxt = {6'd0, snap_r.servo};
      SLOT_DIRECT:   data_nxt = {4'd0, snap_r.direct_kick};
      SLOT_CHIP:     data_nxt = {4'd0, snap_r.chip_kick};
      default:       data_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= SLOT_MOTOR1;
      out_valid_r <= 1'b0;
    end else begin
      if (frame_done) begin
        busy_r <= 1'b1;
        slot_r <= SLOT_MOTOR1;
      end else if (busy_r && can_load) begin
        slot_r <= slot_r + 3'd1;
        if (slot_r == SLOT_CHIP) begin
          busy_r <= 1'b0;
        end
      end
      if (can_load) begin
        out_valid_r <= busy_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (frame_done) begin
      snap_r <= frame;
    end
    if (busy_r && can_load) begin
      out_slot_r      <= slot_r;
      out_data_r      <= data_nxt;
      out_dirs_r      <= snap_r.speed_dir;
      out_ready_lvl_r <= snap_r.charge_ok;
      out_beep_r      <= snap_r.beep;
      out_debug_r     <= snap_r.debug;
      out_sos_r       <= snap_r.sos;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_latch_index = {1'b0, out_slot_r} + LATCH_MOTOR1;
  assign out_mux_select  = out_slot_r[1:0];
  assign out_write_bank  = !out_slot_r[2];
  assign out_latch_data  = out_data_r;
  assign out_motor_dirs  = out_dirs_r;
  assign out_charge_ok   = out_ready_lvl_r;
  assign out_buzzer_on   = out_beep_r;
  assign out_debug_flag  = out_debug_r;
  assign out_sos_flag    = out_sos_r;
  assign out_last        = out_slot_r == SLOT_CHIP;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !busy_r)
    else $error("snapshot overwritten during a burst");

  a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> (busy_r && slot_r == SLOT_MOTOR1))
    else $error("burst did not start from the first motor");

  a_first_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && can_load && slot_r == SLOT_MOTOR1) |=>
      (out_valid_r && out_latch_index == LATCH_MOTOR1))
    else $error("first write of a burst not presented");

endmodule

### design/robot_command_frame_decoder_core.sv
// Robot command frame decoder.
// Input channel (in_valid/in_ready, in_rx_byte): one received serial byte per
// item. A zero byte starts a frame; the next byte must match robot_id in its
// low nibble, then four speed bytes and two flag bytes follow.
// Output channel (out_valid/out_ready, out_*): eight latch writes per finished
// frame, motors 1-4, dribbler, servo, direct kick, chip kick; out_last marks
// the eighth. Level fields are those of the finished frame.
// Configuration: APB-style port, robot_id at byte address 0; pready is tied
// high and writes land on the access cycle.
// Throughput: one byte per cycle. The first write of a burst is registered in
// the output stage after the sequencer has gone busy, then one write per cycle
// while out_ready stays high. For frames sent back to back, the closing
// byte of the next frame is held off (in_ready low) while the sequencer is
// busy, i.e. until the cycle after it has loaded the last write of the
// previous burst; other bytes keep flowing. A stall on the output holds the
// current write in its register and stretches the burst.
// Reset (rst_n, synchronous): waits for a zero byte, stored fields cleared,
// servo setting one, robot_id zero, no write pending.
module robot_command_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_latch_index,
  output logic [1:0]  out_mux_select,
  output logic        out_write_bank,
  output logic [7:0]  out_latch_data,
  output logic [3:0]  out_motor_dirs,
  output logic        out_charge_ok,
  output logic        out_buzzer_on,
  output logic        out_debug_flag,
  output logic        out_sos_flag,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcfd_pkg::*;

  logic [3:0] robot_id_r;
  logic       seq_busy;
  logic       frame_done;
  frame_t     frame;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROBOT_ID) ? {28'd0, robot_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_id_r <= 4'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ROBOT_ID) begin
      robot_id_r <= pwdata[3:0];
    end
  end

  rcfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .robot_id   (robot_id_r),
    .seq_busy   (seq_busy),
    .frame_done (frame_done),
    .frame      (frame)
  );

  rcfd_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame_done      (frame_done),
    .frame           (frame),
    .busy            (seq_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_latch_index (out_latch_index),
    .out_mux_select  (out_mux_select),
    .out_write_bank  (out_write_bank),
    .out_latch_data  (out_latch_data),
    .out_motor_dirs  (out_motor_dirs),
    .out_charge_ok   (out_charge_ok),
    .out_buzzer_on   (out_buzzer_on),
    .out_debug_flag  (out_debug_flag),
    .out_sos_flag    (out_sos_flag),
    .out_last        (out_last)
  );

  a_id_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[2] == REG_ROBOT_ID) |=>
      robot_id_r == $past(pwdata[3:0]))
    else $error("robot id write lost");

  a_no_close_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && frame_done) |-> !seq_busy)
    else $error("frame accepted into a busy sequencer");

  a_last_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (!out_write_bank && out_latch_index == LATCH_CHIP))
    else $error("last write not on the chip kick latch");

endmodule
